// ===== hw/rtl/b3split_pkg.sv =====
// ----------------------------------------------------------------------------
// b3split_pkg
// Shared types and constants for the balanced three-way split search.
// ----------------------------------------------------------------------------
package b3split_pkg;

    // Default sizing of the prefix sum store.
    localparam int MAX_LEN_DEF   = 1024;
    localparam int SUM_WIDTH_DEF = 24;

    // Fixed field widths of the item interfaces.
    localparam int SUM_IN_W = 24;
    localparam int CUT_W    = 11;
    localparam int COST_W   = 55;

    // Smallest run that holds a cut pair.
    localparam int MIN_RUN = 3;

    // One loaded item.
    typedef struct packed {
        logic signed [SUM_IN_W-1:0] prefix_sum;
        logic                       is_last;
        logic [COST_W-1:0]          start_bound;
        logic [CUT_W-1:0]           start_first;
        logic [CUT_W-1:0]           start_second;
    } b3split_in_t;

    // One result item.
    typedef struct packed {
        logic [CUT_W-1:0]  first_cut;
        logic [CUT_W-1:0]  second_cut;
        logic [COST_W-1:0] best_cost;
    } b3split_out_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_T_READ,
        ST_T_WAIT,
        ST_Q_READ,
        ST_Q_WAIT,
        ST_Q_SQUARE,
        ST_Q_CHECK,
        ST_P_RUN,
        ST_DRAIN,
        ST_DONE
    } b3split_state_t;

endpackage

// ===== hw/rtl/balanced_three_way_split.sv =====
// Loading takes one item per cycle; a non-last item is taken every cycle.
// After the last item the search reads the total, then for each second cut
// q reads S[q] and, unless q is skipped, sweeps every first cut below q; the
// single store read port sets the search time. The result is registered in
// ST_DONE once the output is free.
// Reset clears control and the best registers; the store is not cleared.
// ----------------------------------------------------------------------------
// balanced_three_way_split
// Loads a run of prefix sums into a store and searches cut pairs that can beat
// the bound for the three parts whose sums lie closest to a third of the total.
// ----------------------------------------------------------------------------
module balanced_three_way_split #(
    parameter int MAX_LEN   = b3split_pkg::MAX_LEN_DEF,
    parameter int SUM_WIDTH = b3split_pkg::SUM_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load_valid,
    output logic                      load_ready,
    input  b3split_pkg::b3split_in_t  load_item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output b3split_pkg::b3split_out_t result_item
);

    localparam int AW    = $clog2(MAX_LEN);
    localparam int CNTW  = $clog2(MAX_LEN + 1);
    localparam int DW    = SUM_WIDTH + 3;
    localparam int SQW   = 2 * SUM_WIDTH + 4;
    localparam int COSTW = b3split_pkg::COST_W;
    localparam int CUTW  = b3split_pkg::CUT_W;

    b3split_pkg::b3split_state_t state_reg, state_next;

    logic [CNTW-1:0]             count_reg, count_next;
    logic [CNTW-1:0]             count_fill;
    logic [CNTW-1:0]             n_reg, n_next;
    logic [CNTW-1:0]             n_minus1;
    logic [CNTW-1:0]             q_reg, q_next;
    logic [AW-1:0]               p_reg, p_next;
    logic                        p_last;
    logic                        more_q;
    logic signed [SUM_WIDTH-1:0] t_reg, t_next;
    logic signed [SUM_WIDTH-1:0] sq_reg, sq_next;
    logic signed [DW-1:0]        d3_reg, d3_next;
    logic [SQW-1:0]              c3_reg, c3_next;
    logic signed [2*DW-1:0]      d3_prod;
    logic signed [DW-1:0]        t_x;
    logic signed [DW-1:0]        s_x;
    logic [COSTW-1:0]            best_cost_reg, best_cost_next;
    logic [CUTW-1:0]             best_first_reg, best_first_next;
    logic [CUTW-1:0]             best_second_reg, best_second_next;
    logic                        result_valid_reg, result_valid_next;
    b3split_pkg::b3split_out_t   result_reg, result_next;

    logic                        wr_en;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [SUM_WIDTH-1:0]        rd_data;
    logic                        p_issue;
    logic                        rd_valid_reg;
    logic [AW-1:0]               rd_p_reg;

    logic                        cost_valid;
    logic [COSTW-1:0]            cost;
    logic [AW-1:0]               cost_p;
    logic                        pipe_busy;

    // Prefix sum store.
    b3split_sum_mem #(
        .DEPTH (MAX_LEN),
        .WIDTH (SUM_WIDTH),
        .AW    (AW)
    ) u_sum_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (load_item.prefix_sum[SUM_WIDTH-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Cost pipeline for the first cut sweep.
    b3split_cost_pipe #(
        .SUM_WIDTH (SUM_WIDTH),
        .AW        (AW)
    ) u_cost_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid_reg),
        .sp        (rd_data),
        .p_idx     (rd_p_reg),
        .sq        (sq_reg),
        .t         (t_reg),
        .c3        (c3_reg),
        .out_valid (cost_valid),
        .cost      (cost),
        .out_p     (cost_p),
        .busy      (pipe_busy)
    );

    // Helper values for the sequencer.
    assign count_fill = (count_reg < CNTW'(MAX_LEN)) ? count_reg + CNTW'(1) : count_reg;
    assign n_minus1   = n_reg - CNTW'(1);
    assign p_last     = (CNTW'(p_reg) + CNTW'(1)) == q_reg;
    assign more_q     = (q_reg + CNTW'(2)) < n_reg;
    assign t_x        = DW'(t_reg);
    assign s_x        = DW'($signed(rd_data));
    assign d3_prod    = d3_reg * d3_reg;

    // Next state and datapath control.
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        n_next            = n_reg;
        q_next            = q_reg;
        p_next            = p_reg;
        t_next            = t_reg;
        sq_next           = sq_reg;
        d3_next           = d3_reg;
        c3_next           = c3_reg;
        best_cost_next    = best_cost_reg;
        best_first_next   = best_first_reg;
        best_second_next  = best_second_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        load_ready        = 1'b0;
        wr_en             = 1'b0;
        rd_en             = 1'b0;
        rd_addr           = '0;
        p_issue           = 1'b0;

        // A strictly smaller cost from the pipeline replaces the best pair.
        if (cost_valid && (cost < best_cost_reg))
        begin
            best_cost_next   = cost;
            best_first_next  = CUTW'(cost_p + AW'(1));
            best_second_next = CUTW'(q_reg + CNTW'(1));
        end

        unique case (state_reg)
            b3split_pkg::ST_LOAD:
            begin
                load_ready = 1'b1;
                if (load_valid)
                begin
                    // The first item of a run sets the starting bound and cuts.
                    if (count_reg == '0)
                    begin
                        best_cost_next   = load_item.start_bound;
                        best_first_next  = load_item.start_first;
                        best_second_next = load_item.start_second;
                    end
                    wr_en  = count_reg < CNTW'(MAX_LEN);
                    n_next = count_fill;
                    if (load_item.is_last)
                    begin
                        count_next = '0;
                        q_next     = CNTW'(1);
                        if (count_fill < CNTW'(b3split_pkg::MIN_RUN))
                        begin
                            state_next = b3split_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = b3split_pkg::ST_T_READ;
                        end
                    end
                    else
                    begin
                        count_next = count_fill;
                    end
                end
            end

            b3split_pkg::ST_T_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = n_minus1[AW-1:0];
                state_next = b3split_pkg::ST_T_WAIT;
            end

            b3split_pkg::ST_T_WAIT:
            begin
                t_next     = $signed(rd_data);
                state_next = b3split_pkg::ST_Q_READ;
            end

            b3split_pkg::ST_Q_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = q_reg[AW-1:0];
                state_next = b3split_pkg::ST_Q_WAIT;
            end

            b3split_pkg::ST_Q_WAIT:
            begin
                // Third part deviation: 2T - 3S[q].
                sq_next    = $signed(rd_data);
                d3_next    = (t_x <<< 1) - ((s_x <<< 1) + s_x);
                state_next = b3split_pkg::ST_Q_SQUARE;
            end

            b3split_pkg::ST_Q_SQUARE:
            begin
                c3_next    = d3_prod[SQW-1:0];
                state_next = b3split_pkg::ST_Q_CHECK;
            end

            b3split_pkg::ST_Q_CHECK:
            begin
                // Skip this second cut when its third part alone reaches the bound.
                if (COSTW'(c3_reg) >= best_cost_reg)
                begin
                    if (more_q)
                    begin
                        q_next     = q_reg + CNTW'(1);
                        state_next = b3split_pkg::ST_Q_READ;
                    end
                    else
                    begin
                        state_next = b3split_pkg::ST_DONE;
                    end
                end
                else
                begin
                    p_next     = '0;
                    state_next = b3split_pkg::ST_P_RUN;
                end
            end

            b3split_pkg::ST_P_RUN:
            begin
                rd_en   = 1'b1;
                rd_addr = p_reg;
                p_issue = 1'b1;
                p_next  = p_reg + AW'(1);
                if (p_last)
                begin
                    state_next = b3split_pkg::ST_DRAIN;
                end
            end

            b3split_pkg::ST_DRAIN:
            begin
                // Wait until every first cut of this second cut is compared.
                if (!rd_valid_reg && !pipe_busy)
                begin
                    if (more_q)
                    begin
                        q_next     = q_reg + CNTW'(1);
                        state_next = b3split_pkg::ST_Q_READ;
                    end
                    else
                    begin
                        state_next = b3split_pkg::ST_DONE;
                    end
                end
            end

            b3split_pkg::ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.first_cut  = best_first_reg;
                    result_next.second_cut = best_second_reg;
                    result_next.best_cost  = best_cost_reg;
                    result_valid_next      = 1'b1;
                    state_next             = b3split_pkg::ST_LOAD;
                end
            end

            default:
            begin
                state_next = b3split_pkg::ST_LOAD;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= b3split_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control and best-pair registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            n_reg            <= '0;
            q_reg            <= '0;
            p_reg            <= '0;
            best_cost_reg    <= '0;
            best_first_reg   <= '0;
            best_second_reg  <= '0;
            result_valid_reg <= 1'b0;
            rd_valid_reg     <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            n_reg            <= n_next;
            q_reg            <= q_next;
            p_reg            <= p_next;
            best_cost_reg    <= best_cost_next;
            best_first_reg   <= best_first_next;
            best_second_reg  <= best_second_next;
            result_valid_reg <= result_valid_next;
            rd_valid_reg     <= p_issue;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        sq_reg     <= sq_next;
        d3_reg     <= d3_next;
        c3_reg     <= c3_next;
        result_reg <= result_next;
        rd_p_reg   <= p_reg;
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

`ifndef SYNTHESIS
    // The first cut sweep stays below the current second cut.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == b3split_pkg::ST_P_RUN) |-> (CNTW'(p_reg) < q_reg))
    else $error("first cut sweep passed the second cut");

    // A second cut is only read while it lies inside the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == b3split_pkg::ST_Q_READ) |->
            ((n_reg >= CNTW'(b3split_pkg::MIN_RUN)) && ((q_reg + CNTW'(1)) < n_reg)))
    else $error("second cut out of range");

    // Costs leave the pipeline only while a sweep runs or drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        cost_valid |-> ((state_reg == b3split_pkg::ST_P_RUN) ||
                        (state_reg == b3split_pkg::ST_DRAIN)))
    else $error("cost item outside of a sweep");

    // The best cost never rises during a search.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != b3split_pkg::ST_LOAD) |=> (best_cost_reg <= $past(best_cost_reg)))
    else $error("best cost increased during search");
`endif

endmodule

// ===== hw/rtl/b3split_sum_mem.sv =====
// ----------------------------------------------------------------------------
// b3split_sum_mem
// Prefix sum store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module b3split_sum_mem #(
    parameter int DEPTH = b3split_pkg::MAX_LEN_DEF,
    parameter int WIDTH = b3split_pkg::SUM_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/b3split_cost_pipe.sv =====
// ----------------------------------------------------------------------------
// b3split_cost_pipe
// Three-stage cost pipeline: part deviations, squares, and the final sum.
// ----------------------------------------------------------------------------
module b3split_cost_pipe #(
    parameter int SUM_WIDTH = b3split_pkg::SUM_WIDTH_DEF,
    parameter int AW        = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [SUM_WIDTH-1:0]         sp,
    input  logic [AW-1:0]                p_idx,
    input  logic signed [SUM_WIDTH-1:0]  sq,
    input  logic signed [SUM_WIDTH-1:0]  t,
    input  logic [2*SUM_WIDTH+3:0]       c3,
    output logic                         out_valid,
    output logic [b3split_pkg::COST_W-1:0] cost,
    output logic [AW-1:0]                out_p,
    output logic                         busy
);

    localparam int DW    = SUM_WIDTH + 3;
    localparam int SQW   = 2 * SUM_WIDTH + 4;
    localparam int COSTW = b3split_pkg::COST_W;

    logic signed [DW-1:0]   sp_x;
    logic signed [DW-1:0]   sq_x;
    logic signed [DW-1:0]   t_x;
    logic signed [DW-1:0]   d1_next;
    logic signed [DW-1:0]   d2_next;
    logic signed [2*DW-1:0] prod1;
    logic signed [2*DW-1:0] prod2;
    logic [COSTW-1:0]       cost_next;

    logic                   a_valid_reg;
    logic signed [DW-1:0]   a_d1_reg;
    logic signed [DW-1:0]   a_d2_reg;
    logic [AW-1:0]          a_p_reg;
    logic                   b_valid_reg;
    logic [SQW-1:0]         b_s1_reg;
    logic [SQW-1:0]         b_s2_reg;
    logic [AW-1:0]          b_p_reg;
    logic                   c_valid_reg;
    logic [COSTW-1:0]       c_cost_reg;
    logic [AW-1:0]          c_p_reg;

    // Deviations of the first and middle parts, scaled by three.
    assign sp_x    = DW'($signed(sp));
    assign sq_x    = DW'(sq);
    assign t_x     = DW'(t);
    assign d1_next = (sp_x <<< 1) + sp_x - t_x;
    assign d2_next = ((sq_x - sp_x) <<< 1) + (sq_x - sp_x) - t_x;

    // Squares of both deviations.
    assign prod1 = a_d1_reg * a_d1_reg;
    assign prod2 = a_d2_reg * a_d2_reg;

    // Full cost, including the third part's square for this second cut.
    assign cost_next = COSTW'(b_s1_reg) + COSTW'(b_s2_reg) + COSTW'(c3);

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Stage data.
    always_ff @(posedge clk)
    begin
        a_d1_reg   <= d1_next;
        a_d2_reg   <= d2_next;
        a_p_reg    <= p_idx;
        b_s1_reg   <= prod1[SQW-1:0];
        b_s2_reg   <= prod2[SQW-1:0];
        b_p_reg    <= a_p_reg;
        c_cost_reg <= cost_next;
        c_p_reg    <= b_p_reg;
    end

    assign out_valid = c_valid_reg;
    assign cost      = c_cost_reg;
    assign out_p     = c_p_reg;
    assign busy      = a_valid_reg | b_valid_reg | c_valid_reg;

endmodule

// ===== tb/sv/b3split_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b3split_checker
// Watches the load and result channels of the three-way split search. It keeps
// its own copy of the loaded prefix sums and the running best split, works out
// the split that each closing item should produce, and compares every result
// item against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module b3split_checker
    import b3split_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load_valid,
    input  logic         load_ready,
    input  b3split_in_t  load_item,
    input  logic         result_valid,
    input  logic         result_ready,
    input  b3split_out_t result_item,
    output int           mismatch_count,
    output int           splits_pending
);

    // Only the first few mismatches are printed in detail.
    localparam int SHOWN_LIMIT = 10;

    // Mirror of the block's run state.
    logic signed [SUM_IN_W-1:0] run_sums [MAX_LEN_DEF];
    int                         run_len;
    logic [COST_W-1:0]          lead_cost;
    logic [CUT_W-1:0]           lead_first;
    logic [CUT_W-1:0]           lead_second;

    // Predicted splits, oldest first.
    b3split_out_t expected_splits [$];

    // Takes one loaded item into the mirrored run. When the item closes the
    // run, the search over all cut pairs is done here and the winning split
    // is returned with a 1.
    function automatic bit absorb_prefix_sum(input b3split_in_t item,
                                             output b3split_out_t split);
        longint          total;
        longint          s_q;
        longint          s_p;
        longint          d1;
        longint          d2;
        longint          d3;
        longint unsigned c3;
        longint unsigned cost;
        split = '0;
        // The first item of a run seeds the running best.
        if (run_len == 0) begin
            lead_cost   = item.start_bound;
            lead_first  = item.start_first;
            lead_second = item.start_second;
        end
        // Items past the end of the store are dropped.
        if (run_len < MAX_LEN_DEF) begin
            run_sums[run_len] = item.prefix_sum;
            run_len++;
        end
        if (!item.is_last)
            return 1'b0;
        // Search every pair p < q; a q whose third part alone reaches the
        // running best is skipped. Only a strictly smaller cost wins.
        if (run_len >= MIN_RUN) begin
            total = run_sums[run_len-1];
            for (int q = 1; q + 1 < run_len; q++) begin
                s_q = run_sums[q];
                d3  = 2 * total - 3 * s_q;
                c3  = longint'(d3 * d3);
                if (c3 >= lead_cost)
                    continue;
                for (int p = 0; p < q; p++) begin
                    s_p  = run_sums[p];
                    d1   = 3 * s_p - total;
                    d2   = 3 * (s_q - s_p) - total;
                    cost = longint'(d1 * d1) + longint'(d2 * d2) + c3;
                    if (cost < lead_cost) begin
                        lead_cost   = cost[COST_W-1:0];
                        lead_first  = CUT_W'(p + 1);
                        lead_second = CUT_W'(q + 1);
                    end
                end
            end
        end
        split.first_cut  = lead_first;
        split.second_cut = lead_second;
        split.best_cost  = lead_cost;
        run_len = 0;
        return 1'b1;
    endfunction

    // Compare results against predictions, then absorb the loaded item.
    always @(posedge clk or negedge rst_n) begin
        b3split_out_t want;
        b3split_out_t fresh;
        if (!rst_n) begin
            run_len        = 0;
            lead_cost      = '0;
            lead_first     = '0;
            lead_second    = '0;
            mismatch_count = 0;
            splits_pending = 0;
            expected_splits.delete();
        end else begin
            if (result_valid && result_ready) begin
                if (expected_splits.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_LIMIT)
                        $display("%0t: split result with none expected: cuts %0d/%0d cost %0d",
                                 $realtime, result_item.first_cut,
                                 result_item.second_cut, result_item.best_cost);
                end else begin
                    want = expected_splits.pop_front();
                    if (result_item.first_cut !== want.first_cut ||
                        result_item.second_cut !== want.second_cut ||
                        result_item.best_cost !== want.best_cost) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOWN_LIMIT)
                            $display("%0t: split mismatch: expected cuts %0d/%0d cost %0d, got cuts %0d/%0d cost %0d",
                                     $realtime, want.first_cut, want.second_cut,
                                     want.best_cost, result_item.first_cut,
                                     result_item.second_cut, result_item.best_cost);
                    end
                end
            end
            if (load_valid && load_ready) begin
                if (absorb_prefix_sum(load_item, fresh))
                    expected_splits.push_back(fresh);
            end
            splits_pending = expected_splits.size();
        end
    end

endmodule

// ===== tb/sv/tb_balanced_three_way_split.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_balanced_three_way_split
// Drives runs of prefix sums into the three-way split search, with random
// gaps on the load side and random back-pressure on the result side, and
// leaves all checking to the checker beside the block. Directed runs cover
// the field extremes, short runs, skipped cuts, ties and a full store; the
// random runs mix wide, rising, flat and rail sums of random length and bound.
// ----------------------------------------------------------------------------
module tb_balanced_three_way_split
    import b3split_pkg::*;
;

    localparam int RANDOM_ITEMS   = 450;
    localparam int FULL_RUN_LEN   = MAX_LEN_DEF + 2;
    localparam int LONG_HOLD      = 2500;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 100000;

    localparam logic signed [SUM_IN_W-1:0] SUM_LOW  = {1'b1, {(SUM_IN_W-1){1'b0}}};
    localparam logic signed [SUM_IN_W-1:0] SUM_HIGH = {1'b0, {(SUM_IN_W-1){1'b1}}};
    localparam logic [COST_W-1:0]          COST_TOP = '1;

    // Shapes of generated prefix sum runs.
    typedef enum logic [1:0] {
        SUMS_WIDE,
        SUMS_RISING,
        SUMS_FLAT,
        SUMS_RAIL
    } sum_kind_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         load_valid = 1'b0;
    logic         load_ready;
    b3split_in_t  load_item = '0;
    logic         result_valid;
    logic         result_ready = 1'b0;
    b3split_out_t result_item;

    int mismatch_total;
    int splits_waiting;
    int quiet_cycles = 0;
    int items_sent = 0;
    bit sender_burst = 1'b0;
    bit hold_off_req = 1'b0;
    bit hold_active = 1'b0;

    // Prefix sums of the next run to be sent.
    logic signed [SUM_IN_W-1:0] next_sums [$];

    balanced_three_way_split i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (load_valid),
        .load_ready   (load_ready),
        .load_item    (load_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    b3split_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .load_valid     (load_valid),
        .load_ready     (load_ready),
        .load_item      (load_item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result_item    (result_item),
        .mismatch_count (mismatch_total),
        .splits_pending (splits_waiting)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort when no item moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((load_valid && load_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [COST_W-1:0] wide_random();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[COST_W-1:0];
    endfunction

    // Appends a generated run of prefix sums.
    function automatic void fill_sums(input sum_kind_t kind, input int len);
        int acc;
        acc = int'($urandom_range(0, 40)) - 20;
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                SUMS_WIDE:
                    next_sums.push_back(SUM_IN_W'($urandom));
                SUMS_RISING:
                begin
                    acc = acc + int'($urandom_range(0, 20));
                    next_sums.push_back(SUM_IN_W'(acc));
                end
                SUMS_FLAT:
                    next_sums.push_back(SUM_IN_W'(int'($urandom_range(0, 4)) - 2));
                default:
                    case ($urandom_range(0, 3))
                        0: next_sums.push_back(SUM_LOW);
                        1: next_sums.push_back(SUM_HIGH);
                        2: next_sums.push_back('0);
                        default: next_sums.push_back('1);
                    endcase
            endcase
        end
    endfunction

    // Sends the queued run, one item per handshake. The start fields matter
    // only on the first item; later items carry noise there.
    task automatic ship_run(input logic [COST_W-1:0] bound,
                            input logic [CUT_W-1:0] first,
                            input logic [CUT_W-1:0] second);
        b3split_in_t item;
        int          gap;
        for (int i = 0; i < next_sums.size(); i++)
        begin
            item.prefix_sum   = next_sums[i];
            item.is_last      = (i == next_sums.size() - 1);
            item.start_bound  = (i == 0) ? bound : wide_random();
            item.start_first  = (i == 0) ? first : CUT_W'($urandom_range(0, 2047));
            item.start_second = (i == 0) ? second : CUT_W'($urandom_range(0, 2047));
            gap = sender_burst ? 0 : idle_len();
            @(negedge clk);
            if (gap > 0)
            begin
                load_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            load_valid <= 1'b1;
            load_item  <= item;
            do
                @(posedge clk);
            while (!load_ready);
            items_sent++;
        end
        next_sums.delete();
    endtask

    // Result side: random stalls, ready bursts, and one long hold-off on request.
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_active  = 1'b1;
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_active = 1'b0;
            end
            else if ($urandom_range(0, 9) < 2)
            begin
                result_ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                stall = idle_len();
                if (stall > 0)
                begin
                    result_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
        end
    end

    // Load side stimulus and final verdict.
    initial
    begin
        int                goal;
        int                len;
        int                roll;
        int                big_runs;
        sum_kind_t         kind;
        logic [COST_W-1:0] bound;
        big_runs = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Single item run: no pair exists, the start values come back.
        next_sums.push_back(SUM_LOW);
        ship_run(COST_TOP, 11'd2047, 11'd2047);
        // Two items: still no pair.
        next_sums.push_back(SUM_HIGH);
        next_sums.push_back('1);
        ship_run('0, 11'd0, 11'd1024);
        // Smallest searchable run at the sum extremes.
        next_sums.push_back(SUM_LOW);
        next_sums.push_back(SUM_HIGH);
        next_sums.push_back(SUM_LOW);
        ship_run(COST_TOP, 11'd5, 11'd6);
        // A zero bound skips every second cut.
        for (int i = 1; i <= 3; i++)
            next_sums.push_back(SUM_IN_W'(i));
        ship_run('0, 11'd1024, 11'd0);
        // All-zero sums tie everywhere; the first pair must be kept.
        for (int i = 0; i < 5; i++)
            next_sums.push_back('0);
        ship_run(COST_TOP, 11'd3, 11'd4);
        // Perfectly balanced split exists at cuts 2 and 4.
        for (int i = 1; i <= 6; i++)
            next_sums.push_back(SUM_IN_W'(3 * i));
        sender_burst = 1'b1;
        ship_run(wide_random(), 11'd1, 11'd2);
        // Tiny bound with swinging sums.
        next_sums.push_back(SUM_HIGH);
        next_sums.push_back(SUM_LOW);
        next_sums.push_back(SUM_HIGH);
        next_sums.push_back(SUM_LOW);
        sender_burst = 1'b0;
        ship_run(55'd1, 11'd7, 11'd8);

        // Overfull run: the extra items are dropped and the closing item
        // arrives with the store already full.
        fill_sums(SUMS_RISING, FULL_RUN_LEN);
        ship_run(COST_W'($urandom_range(0, 400)), CUT_W'($urandom_range(0, 2047)),
                 CUT_W'($urandom_range(0, 2047)));

        // Let the long search finish and its result leave, so that the hold
        // below falls on short runs only.
        @(negedge clk);
        load_valid <= 1'b0;
        while (splits_waiting != 0)
            @(negedge clk);

        // Hold results back while short runs keep coming, so the input stalls.
        hold_off_req = 1'b1;
        wait (hold_active);
        for (int r = 0; r < 4; r++)
        begin
            fill_sums(SUMS_RISING, $urandom_range(3, 5));
            ship_run(COST_TOP, CUT_W'($urandom_range(0, 2047)),
                     CUT_W'($urandom_range(0, 2047)));
        end

        // Random runs, mostly short and well formed.
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                len = $urandom_range(1, 2);
            else if (roll < 85)
                len = $urandom_range(3, 12);
            else if (roll < 98 || big_runs >= 2)
                len = $urandom_range(13, 40);
            else
            begin
                len = $urandom_range(100, 150);
                big_runs++;
            end
            roll = $urandom_range(0, 99);
            if (roll < 15)
                kind = SUMS_WIDE;
            else if (roll < 60)
                kind = SUMS_RISING;
            else if (roll < 80)
                kind = SUMS_FLAT;
            else
                kind = SUMS_RAIL;
            roll = $urandom_range(0, 99);
            if (roll < 55)
                bound = COST_TOP;
            else if (roll < 75)
                bound = wide_random();
            else if (roll < 90)
                bound = wide_random() >> $urandom_range(0, COST_W - 1);
            else
                bound = COST_W'($urandom_range(0, 64));
            sender_burst = ($urandom_range(0, 3) == 0);
            fill_sums(kind, len);
            ship_run(bound, CUT_W'($urandom_range(0, 2047)),
                     CUT_W'($urandom_range(0, 2047)));
        end
        @(negedge clk);
        load_valid <= 1'b0;

        // Wait out the last search, then a short tail for stray results.
        while (splits_waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_total == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== balanced_three_way_split.f =====
hw/rtl/b3split_pkg.sv
hw/rtl/b3split_sum_mem.sv
hw/rtl/b3split_cost_pipe.sv
hw/rtl/balanced_three_way_split.sv
tb/sv/b3split_checker.sv
tb/sv/tb_balanced_three_way_split.sv
